// ===== rtl/srdd_pkg.sv =====
package srdd_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEAD_ZONE = 2'd0,
    CFG_ROTATION  = 2'd1,
    CFG_ENABLE    = 2'd2
  } cfg_reg_e;

  // register widths and reset values
  localparam int unsigned DZ_W  = 15;
  localparam int unsigned ROT_W = 2;
  localparam logic [DZ_W-1:0]  DZ_RESET  = 15'd8000;
  localparam logic [ROT_W-1:0] ROT_RESET = 2'd0;

  // rotation codes
  localparam logic [ROT_W-1:0] ROT_QUARTER       = 2'd1;
  localparam logic [ROT_W-1:0] ROT_THREE_QUARTER = 2'd3;

  // fixed point constants
  localparam logic [14:0] SLOPE_Q16  = 15'd27146;
  localparam logic [14:0] FULL_SCALE = 15'd32767;
  localparam logic [16:0] SCALE_BASE = 17'd32769;

  // four-way direction flags
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } dir_t;

  localparam int unsigned DIR_W = 4;

endpackage

// ===== rtl/srdd_sqrt.sv =====
module srdd_sqrt #(
  parameter int unsigned IN_W   = 48,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [IN_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int unsigned RT_W = IN_W / 2;
  localparam int unsigned R_W  = RT_W + 2;

  logic [RT_W-1:0] v_q;
  logic [R_W-1:0]    rem_q  [RT_W];
  logic [RT_W-1:0]   root_q [RT_W];
  logic [IN_W-1:0]   rad_q  [RT_W];
  logic [SIDE_W-1:0] side_q [RT_W];

  // one root bit per stage, two radicand bits brought down each step
  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    logic              v_in;
    logic [R_W-1:0]    rem_in;
    logic [RT_W-1:0]   root_in;
    logic [IN_W-1:0]   rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [R_W-1:0]    trial_rem;
    logic [R_W-1:0]    trial;
    logic [R_W-1:0]    rem_d;
    logic [RT_W-1:0]   root_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      trial_rem = {rem_in[R_W-3:0], rad_in[IN_W-1 -: 2]};
      trial     = {root_in, 2'b01};
      if (trial_rem >= trial) begin
        rem_d  = trial_rem - trial;
        root_d = {root_in[RT_W-2:0], 1'b1};
      end else begin
        rem_d  = trial_rem;
        root_d = {root_in[RT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
      rad_q[k]  <= {rad_in[IN_W-3:0], 2'b00};
      side_q[k] <= side_in;
    end
  end

  assign valid_o = v_q[RT_W-1];
  assign root_o  = root_q[RT_W-1];
  assign side_o  = side_q[RT_W-1];

endmodule

// ===== rtl/srdd_div.sv =====
module srdd_div #(
  parameter int unsigned NUM_W  = 55,
  parameter int unsigned DEN_W  = 40,
  parameter int unsigned QW     = 30,
  parameter int unsigned SIDE_W = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QW-1:0]     quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned HI_W = NUM_W - QW;

  logic [QW-1:0] v_q;
  logic [DEN_W-1:0]  rem_q  [QW];
  logic [QW-1:0]     lo_q   [QW];
  logic [QW-1:0]     quo_q  [QW];
  logic [DEN_W-1:0]  den_q  [QW];
  logic [SIDE_W-1:0] side_q [QW];

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic              v_in;
    logic [DEN_W-1:0]  rem_in;
    logic [QW-1:0]     lo_in;
    logic [QW-1:0]     quo_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [DEN_W-1:0]  rem_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = {{(DEN_W-HI_W){1'b0}}, num_i[NUM_W-1:QW]};
      assign lo_in   = num_i[QW-1:0];
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign lo_in   = lo_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      trial = {rem_in, lo_in[QW-1]};
      diff  = trial - {1'b0, den_in};
      ge    = (trial >= {1'b0, den_in});
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      lo_q[k]   <= {lo_in[QW-2:0], 1'b0};
      quo_q[k]  <= {quo_in[QW-2:0], ge};
      den_q[k]  <= den_in;
      side_q[k] <= side_in;
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ===== rtl/srdd_stick.sv =====
module srdd_stick #(
  parameter int unsigned SB = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [SB-1:0]          x_i,
  input  logic signed [SB-1:0]          y_i,
  input  logic [srdd_pkg::DZ_W-1:0]     dead_zone_i,
  output logic                          valid_o,
  output logic signed [SB-1:0]          x_o,
  output logic signed [SB-1:0]          y_o,
  output srdd_pkg::dir_t                dirs_o
);

  localparam int unsigned SQ_W   = 2 * SB;
  localparam int unsigned RAD_W  = SQ_W + 16;
  localparam int unsigned MAG_W  = SB + 8;
  localparam int unsigned DZ8_W  = srdd_pkg::DZ_W + 8;
  localparam int unsigned CMP_W  = (MAG_W > DZ8_W) ? MAG_W : DZ8_W;
  localparam int unsigned K_W    = SB + 15;
  localparam int unsigned NUM_W  = K_W + MAG_W;
  localparam int unsigned DEN_W  = MAG_W + 16;
  localparam int unsigned QW     = SB + 14;
  localparam int unsigned SIDE_W = srdd_pkg::DIR_W + 2 + 2 * SB;
  localparam int unsigned XS_W   = srdd_pkg::DIR_W + 2;

  // stage 1: magnitudes, signs and squares
  logic          v1_q;
  logic [SB-1:0] ax1_q, ay1_q;
  logic          xpos1_q, xneg1_q, yneg1_q;
  logic [SQ_W-1:0] sqx1_q, sqy1_q;
  logic [SB-1:0] ax_d, ay_d;

  always_comb begin
    ax_d = x_i[SB-1] ? (~x_i + 1'b1) : x_i;
    ay_d = y_i[SB-1] ? (~y_i + 1'b1) : y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ax1_q   <= ax_d;
    ay1_q   <= ay_d;
    xneg1_q <= x_i[SB-1];
    xpos1_q <= !x_i[SB-1] && (x_i != '0);
    yneg1_q <= y_i[SB-1];
    sqx1_q  <= SQ_W'(x_i * x_i);
    sqy1_q  <= SQ_W'(y_i * y_i);
  end

  // stage 2: sum of squares and zone decode
  logic            v2_q;
  logic [RAD_W-1:0] rad2_q;
  srdd_pkg::dir_t  dirs2_q;
  logic [SB-1:0]   ax2_q, ay2_q;
  logic            xneg2_q, yneg2_q;
  logic [SQ_W-1:0] sq_d;
  logic            vert_d, horiz_d;
  srdd_pkg::dir_t  dirs_d;

  always_comb begin
    sq_d    = sqx1_q + sqy1_q;
    vert_d  = {ay1_q, 16'b0} > (SB+16)'(srdd_pkg::SLOPE_Q16 * ax1_q);
    horiz_d = {ax1_q, 16'b0} > (SB+16)'(srdd_pkg::SLOPE_Q16 * ay1_q);
    dirs_d.up    = vert_d && yneg1_q;
    dirs_d.down  = vert_d && !yneg1_q;
    dirs_d.right = horiz_d && xpos1_q;
    dirs_d.left  = horiz_d && !xpos1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad2_q  <= {sq_d, 16'b0};
    dirs2_q <= dirs_d;
    ax2_q   <= ax1_q;
    ay2_q   <= ay1_q;
    xneg2_q <= xneg1_q;
    yneg2_q <= yneg1_q;
  end

  // magnitude in 16.8 fixed point
  logic             sq_valid;
  logic [MAG_W-1:0] mag;
  logic [SIDE_W-1:0] sq_side;
  srdd_pkg::dir_t   sq_dirs;
  logic             sq_xneg, sq_yneg;
  logic [SB-1:0]    sq_ax, sq_ay;

  srdd_sqrt #(
    .IN_W   (RAD_W),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .rad_i   (rad2_q),
    .side_i  ({dirs2_q, xneg2_q, yneg2_q, ax2_q, ay2_q}),
    .valid_o (sq_valid),
    .root_o  (mag),
    .side_o  (sq_side)
  );

  assign {sq_dirs, sq_xneg, sq_yneg, sq_ax, sq_ay} = sq_side;

  // stage 3: dead zone test, offset and first factors
  logic             v3_q;
  logic             zero3_q, xneg3_q, yneg3_q;
  srdd_pkg::dir_t   dirs3_q;
  logic [MAG_W-1:0] mag3_q, diff3_q;
  logic [K_W-1:0]   kx3_q, ky3_q;
  logic [15:0]      sb3_q;
  logic [CMP_W-1:0] mag_c, dz8_c, diff_c;
  logic [16:0]      sb_full;

  always_comb begin
    mag_c   = CMP_W'(mag);
    dz8_c   = CMP_W'({dead_zone_i, 8'b0});
    diff_c  = mag_c - dz8_c;
    sb_full = srdd_pkg::SCALE_BASE - {2'b00, dead_zone_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    zero3_q <= (mag_c < dz8_c) || (mag == '0);
    xneg3_q <= sq_xneg;
    yneg3_q <= sq_yneg;
    dirs3_q <= sq_dirs;
    mag3_q  <= mag;
    diff3_q <= diff_c[MAG_W-1:0];
    kx3_q   <= K_W'(sq_ax * srdd_pkg::FULL_SCALE);
    ky3_q   <= K_W'(sq_ay * srdd_pkg::FULL_SCALE);
    sb3_q   <= sb_full[15:0];
  end

  // stage 4: numerators and divisor
  logic             v4_q;
  logic [NUM_W-1:0] numx4_q, numy4_q;
  logic [DEN_W-1:0] den4_q;
  logic             zero4_q, xneg4_q, yneg4_q;
  srdd_pkg::dir_t   dirs4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    numx4_q <= NUM_W'(kx3_q * diff3_q);
    numy4_q <= NUM_W'(ky3_q * diff3_q);
    den4_q  <= DEN_W'(mag3_q * sb3_q);
    zero4_q <= zero3_q;
    xneg4_q <= xneg3_q;
    yneg4_q <= yneg3_q;
    dirs4_q <= dirs3_q;
  end

  // per-axis dividers
  logic            dx_valid, dy_valid;
  logic [QW-1:0]   qx, qy;
  logic [XS_W-1:0] dx_side;
  logic            dy_side;
  logic            d_zero, d_xneg;
  srdd_pkg::dir_t  d_dirs;

  srdd_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W),
    .QW     (QW),
    .SIDE_W (XS_W)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .num_i   (numx4_q),
    .den_i   (den4_q),
    .side_i  ({zero4_q, xneg4_q, dirs4_q}),
    .valid_o (dx_valid),
    .quo_o   (qx),
    .side_o  (dx_side)
  );

  srdd_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W),
    .QW     (QW),
    .SIDE_W (1)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .num_i   (numy4_q),
    .den_i   (den4_q),
    .side_i  (yneg4_q),
    .valid_o (dy_valid),
    .quo_o   (qy),
    .side_o  (dy_side)
  );

  assign {d_zero, d_xneg, d_dirs} = dx_side;

  // stage 5: sign restore and dead zone blanking
  logic          v5_q;
  logic [SB-1:0] x_d, y_d;

  always_comb begin
    x_d = d_xneg ? (~qx[SB-1:0] + 1'b1) : qx[SB-1:0];
    y_d = dy_side ? (~qy[SB-1:0] + 1'b1) : qy[SB-1:0];
    if (d_zero) begin
      x_d = '0;
      y_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= dx_valid && dy_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    x_o    <= x_d;
    y_o    <= y_d;
    dirs_o <= d_zero ? srdd_pkg::dir_t'('0) : d_dirs;
  end

  assign valid_o = v5_q;

endmodule

// ===== rtl/stick_radial_deadzone_dpad_unit.sv =====
// Two-stick radial dead zone and eight-way direction unit.
// Input: a transaction is taken at each rising edge with start_i high and
// busy_o low. busy_o is always low, so one stick sample pair can enter
// every cycle; the block is a fully pipelined datapath.
// Output: each result is shown for one cycle with result_valid_o high.
// From the accepting edge to the result the pipeline holds two input
// stages, one root bit per stage of the square root pipe (SAMPLE_BITS+8
// stages), two scaling stages, one quotient bit per stage of the divider
// pipe (SAMPLE_BITS+14 stages) and two output stages.
// Throughput: one transaction per cycle.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high. Index 0 is the dead zone, 1 the rotation,
// 2 the enable; other indexes are ignored. Write only while idle.
// Reset: clears all pipeline valid bits and loads dead zone 8000, no
// rotation and enabled. The receiver cannot stall, so no backpressure
// path exists.
module stick_radial_deadzone_dpad_unit #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [SAMPLE_BITS-1:0]     left_x_i,
  input  logic signed [SAMPLE_BITS-1:0]     left_y_i,
  input  logic signed [SAMPLE_BITS-1:0]     right_x_i,
  input  logic signed [SAMPLE_BITS-1:0]     right_y_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [srdd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [srdd_pkg::DZ_W-1:0]         cfg_data_i,
  output logic                              result_valid_o,
  output logic signed [SAMPLE_BITS-1:0]     left_x_scaled_o,
  output logic signed [SAMPLE_BITS-1:0]     left_y_scaled_o,
  output logic signed [SAMPLE_BITS-1:0]     right_x_scaled_o,
  output logic signed [SAMPLE_BITS-1:0]     right_y_scaled_o,
  output logic                              dir_up_o,
  output logic                              dir_down_o,
  output logic                              dir_left_o,
  output logic                              dir_right_o
);

  logic [srdd_pkg::DZ_W-1:0]  dz_q;
  logic [srdd_pkg::ROT_W-1:0] rot_q;
  logic                       en_q;
  logic                       accept;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q  <= srdd_pkg::DZ_RESET;
      rot_q <= srdd_pkg::ROT_RESET;
      en_q  <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        srdd_pkg::CFG_DEAD_ZONE: dz_q  <= cfg_data_i;
        srdd_pkg::CFG_ROTATION:  rot_q <= cfg_data_i[srdd_pkg::ROT_W-1:0];
        srdd_pkg::CFG_ENABLE:    en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stick lanes
  logic                   l_valid, r_valid;
  logic [SAMPLE_BITS-1:0] l_x, l_y, r_x, r_y;
  srdd_pkg::dir_t         l_dirs, r_dirs;

  srdd_stick #(.SB(SAMPLE_BITS)) u_left (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .x_i         (left_x_i),
    .y_i         (left_y_i),
    .dead_zone_i (dz_q),
    .valid_o     (l_valid),
    .x_o         (l_x),
    .y_o         (l_y),
    .dirs_o      (l_dirs)
  );

  srdd_stick #(.SB(SAMPLE_BITS)) u_right (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .x_i         (right_x_i),
    .y_i         (right_y_i),
    .dead_zone_i (dz_q),
    .valid_o     (r_valid),
    .x_o         (r_x),
    .y_o         (r_y),
    .dirs_o      (r_dirs)
  );

  // merge both sticks, rotate, gate by enable
  srdd_pkg::dir_t any_d, rot_d;

  always_comb begin
    any_d = srdd_pkg::dir_t'(l_dirs | r_dirs);
    case (rot_q)
      srdd_pkg::ROT_QUARTER: begin
        rot_d.up    = any_d.left;
        rot_d.down  = any_d.right;
        rot_d.left  = any_d.down;
        rot_d.right = any_d.up;
      end
      srdd_pkg::ROT_THREE_QUARTER: begin
        rot_d.up    = any_d.right;
        rot_d.down  = any_d.left;
        rot_d.left  = any_d.up;
        rot_d.right = any_d.down;
      end
      default: begin
        rot_d = any_d;
      end
    endcase
    if (!en_q) begin
      rot_d = '0;
    end
  end

  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= l_valid && r_valid;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    left_x_scaled_o  <= en_q ? l_x : '0;
    left_y_scaled_o  <= en_q ? l_y : '0;
    right_x_scaled_o <= en_q ? r_x : '0;
    right_y_scaled_o <= en_q ? r_y : '0;
    dir_up_o         <= rot_d.up;
    dir_down_o       <= rot_d.down;
    dir_left_o       <= rot_d.left;
    dir_right_o      <= rot_d.right;
  end

  assign result_valid_o = valid_q;

endmodule
